/* design/obps_pkg.sv */
// Package: sieve geometry constants and shared types for the odd bitmap prime tester.
package obps_pkg;

  localparam int unsigned Limit      = 65536;
  localparam int unsigned SieveWords = (Limit + 63) / 64;
  localparam int unsigned WordAw     = (SieveWords > 1) ? $clog2(SieveWords) : 1;
  localparam int unsigned NumW       = 32;
  localparam int unsigned CandW      = $clog2(Limit) + 1;

  // Handshake between the sequencer and the shared remainder unit
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] dividend;
    logic [CandW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic zero_rem;
  } div_rsp_t;

endpackage

/* design/obps_if.sv */
// Interfaces: query request channel and result channel.
interface obps_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] number;
  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface obps_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] number_echo;
  logic        is_prime;
  modport source (output valid, output number_echo, output is_prime, input ready);
  modport sink   (input valid, input number_echo, input is_prime, output ready);
endinterface

/* design/obps_div.sv */
// Shared restoring remainder unit: one quotient bit per cycle.
module obps_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  obps_pkg::div_req_t  req_i,
  output obps_pkg::div_rsp_t  rsp_o
);
  import obps_pkg::*;

  logic [NumW-1:0]  dvd_q, dvd_d;
  logic [CandW:0]   rem_q, rem_d;
  logic [CandW-1:0] dvs_q, dvs_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [CandW:0]   shifted;
  logic [CandW:0]   diff;

  assign shifted = {rem_q[CandW-1:0], dvd_q[NumW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  // Load on start, else shift one dividend bit in, subtract if it fits
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[NumW-2:0], 1'b0};
      rem_d = diff[CandW] ? shifted : diff;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.zero_rem = (rem_q == '0);
endmodule

/* design/odd_bitmap_prime_sieve_test_top.sv */
// Top level: sieve builder, bitmap memory and trial-division sequencer.
//
//  channel   dir  payload                 handshake
//  req_if    in   number[31:0]            valid/ready
//  rsp_if    out  number_echo, is_prime   valid/ready
//
// After reset the sieve runs: one bitmap word cleared per cycle, then one bit
// marked per read-modify-write (StInner, StInRd, StInWr); no request taken meanwhile.
// An odd query from 3 to below Limit is looked up in the bitmap (StLkRd, StLkChk).
// A larger odd query walks odd trial divisors: a composite one is skipped after a
// bitmap read, a prime one goes through the shared remainder unit. Numbers below 3
// and even numbers are answered without a lookup.
// The result is held until taken; the next request is taken once it leaves.
module odd_bitmap_prime_sieve_test_top (
  input logic      clk_i,
  input logic      rst_ni,
  obps_req_if.sink   req_if,
  obps_rsp_if.source rsp_if
);
  import obps_pkg::*;

  localparam logic [3:0] StClr   = 4'd0;
  localparam logic [3:0] StOuter = 4'd1;
  localparam logic [3:0] StOutRd = 4'd2;
  localparam logic [3:0] StInner = 4'd3;
  localparam logic [3:0] StInRd  = 4'd4;
  localparam logic [3:0] StInWr  = 4'd5;
  localparam logic [3:0] StIdle  = 4'd6;
  localparam logic [3:0] StLkRd  = 4'd7;
  localparam logic [3:0] StLkChk = 4'd8;
  localparam logic [3:0] StTdNxt = 4'd9;
  localparam logic [3:0] StTdRd  = 4'd10;
  localparam logic [3:0] StTdChk = 4'd11;
  localparam logic [3:0] StTdDiv = 4'd12;
  localparam logic [3:0] StTdEnd = 4'd13;
  localparam logic [3:0] StOut   = 4'd14;

  logic [3:0]       st_q, st_d;
  logic [CandW-1:0] i_q, i_d;       // outer sieve index / trial divisor
  logic [CandW:0]   j_q, j_d;       // inner sieve multiple
  logic [NumW-1:0]  num_q, num_d;
  logic             prime_q, prime_d;
  logic [WordAw-1:0] clr_q, clr_d;

  // Bitmap memory
  logic [31:0]       mem [SieveWords];
  logic [31:0]       rd_q;
  logic [WordAw-1:0] addr;
  logic              we;
  logic [31:0]       wdata;
  logic [NumW-1:0]   probe;
  logic              probe_bit;
  logic [2*CandW-1:0] sq;

  div_req_t dreq;
  div_rsp_t drsp;

  obps_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Number whose bitmap bit is addressed this cycle
  always_comb begin
    case (st_q)
      StOuter, StOutRd:          probe = NumW'(i_q);
      StInner, StInRd, StInWr:   probe = NumW'(j_q);
      StTdNxt, StTdRd, StTdChk:  probe = NumW'(i_q);
      default:                   probe = num_q;
    endcase
  end

  assign addr      = (st_q == StClr) ? clr_q : WordAw'(probe >> 6);
  assign probe_bit = rd_q[probe[5:1]];
  assign wdata     = (st_q == StClr) ? 32'd0 : (rd_q | (32'd1 << probe[5:1]));
  assign we        = (st_q == StClr) || (st_q == StInWr);
  assign sq        = i_q * i_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rd_q <= mem[addr];
  end

  // Sequencer
  always_comb begin
    st_d    = st_q;
    i_d     = i_q;
    j_d     = j_q;
    num_d   = num_q;
    prime_d = prime_q;
    clr_d   = clr_q;
    dreq.start    = 1'b0;
    dreq.dividend = num_q;
    dreq.divisor  = i_q;
    case (st_q)
      StClr: begin
        clr_d = clr_q + WordAw'(1);
        if (32'(clr_q) == SieveWords - 1) begin
          i_d  = CandW'(3);
          st_d = StOuter;
        end
      end
      StOuter: begin
        if (64'(sq) < 64'(Limit)) st_d = StOutRd;
        else st_d = StIdle;
      end
      StOutRd: begin
        if (probe_bit) begin
          i_d  = i_q + CandW'(2);
          st_d = StOuter;
        end else begin
          j_d  = (CandW+1)'(sq);
          st_d = StInner;
        end
      end
      StInner: begin
        if (32'(j_q) < Limit) st_d = StInRd;
        else begin
          i_d  = i_q + CandW'(2);
          st_d = StOuter;
        end
      end
      StInRd: st_d = StInWr;
      StInWr: begin
        j_d  = j_q + {i_q, 1'b0};
        st_d = StInner;
      end
      StIdle: begin
        if (req_if.valid) begin
          num_d = req_if.number;
          if (req_if.number < 32'd2) begin
            prime_d = 1'b0; st_d = StOut;
          end else if (req_if.number == 32'd2) begin
            prime_d = 1'b1; st_d = StOut;
          end else if (!req_if.number[0]) begin
            prime_d = 1'b0; st_d = StOut;
          end else if (64'(req_if.number) < 64'(Limit)) begin
            st_d = StLkRd;
          end else begin
            i_d     = CandW'(3);
            prime_d = 1'b1;
            st_d    = StTdNxt;
          end
        end
      end
      StLkRd:  st_d = StLkChk;
      StLkChk: begin
        prime_d = !probe_bit;
        st_d    = StOut;
      end
      StTdNxt: begin
        if (32'(i_q) < Limit && 64'(sq) <= 64'(num_q)) st_d = StTdRd;
        else st_d = StOut;
      end
      StTdRd: st_d = StTdChk;
      StTdChk: begin
        if (probe_bit) begin
          i_d  = i_q + CandW'(2);
          st_d = StTdNxt;
        end else begin
          dreq.start = 1'b1;
          st_d = StTdDiv;
        end
      end
      StTdDiv: if (!drsp.busy) st_d = StTdEnd;
      StTdEnd: begin
        if (drsp.zero_rem) begin
          prime_d = 1'b0; st_d = StOut;
        end else begin
          i_d  = i_q + CandW'(2);
          st_d = StTdNxt;
        end
      end
      StOut: if (rsp_if.ready) st_d = StIdle;
      default: st_d = StClr;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StClr;
      clr_q <= '0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    num_q   <= num_d;
    prime_q <= prime_d;
  end

  assign req_if.ready       = (st_q == StIdle);
  assign rsp_if.valid       = (st_q == StOut);
  assign rsp_if.number_echo = num_q;
  assign rsp_if.is_prime    = prime_q;
endmodule

/* design/obps_chk.sv */
// Checker: port-level properties of the prime tester, bound to the top level.
module obps_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_number,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_echo,
  input logic        out_prime
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("request taken while result pending");
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> $stable(out_echo) || out_echo == $past(in_number))
    else $error("echo mismatch");
  a_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_echo[0] && out_echo != 32'd2) |-> !out_prime)
    else $error("even number reported prime");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid && $stable(out_prime))
    else $error("result dropped");
endmodule

bind odd_bitmap_prime_sieve_test_top obps_chk u_chk (
  .clk_i, .rst_ni,
  .in_valid(req_if.valid), .in_ready(req_if.ready), .in_number(req_if.number),
  .out_valid(rsp_if.valid), .out_ready(rsp_if.ready),
  .out_echo(rsp_if.number_echo), .out_prime(rsp_if.is_prime)
);

/* verif/odd_bitmap_prime_sieve_test_top_tb.sv */
// Testbench: primality queries against a sieve-backed predictor, with random idling.
`timescale 1ns / 1ps

module odd_bitmap_prime_sieve_test_top_tb;
  import obps_pkg::*;

  localparam int unsigned IdleLimit = 2000000;
  localparam int unsigned MaxShown  = 10;

  typedef struct {
    logic [NumW-1:0] number;
    logic            prime;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  obps_req_if req_if ();
  obps_rsp_if rsp_if ();

  odd_bitmap_prime_sieve_test_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if.sink),
    .rsp_if (rsp_if.source)
  );

  bit          composite_map [Limit];
  verdict_t    verdict_q [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned answered = 0;
  int unsigned primes_seen = 0;
  int unsigned big_queries = 0;
  int unsigned idle_cycles = 0;

  // Toggle the clock
  always #2 clk_i = ~clk_i;

  // Mark odd composites below Limit
  task automatic build_composite_map();
    longint unsigned i, j;
    foreach (composite_map[k]) composite_map[k] = 1'b0;
    for (i = 3; i * i < Limit; i += 2) begin
      if (!composite_map[i]) begin
        for (j = i * i; j < Limit; j += 2 * i) composite_map[j] = 1'b1;
      end
    end
  endtask

  function automatic logic predict_prime(logic [NumW-1:0] n);
    longint unsigned p;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    if (n < Limit) return !composite_map[n];
    for (p = 3; p < Limit && p * p <= n; p += 2) begin
      if (!composite_map[p] && (longint'(n) % p) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offer one request, idling at random first; valid stays high afterwards
  task automatic send_query(logic [NumW-1:0] n);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.number <= n;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    v.number = n;
    v.prime  = predict_prime(n);
    if (n >= Limit) big_queries++;
    verdict_q = {verdict_q, v};
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // Check each result
  always @(posedge clk_i) begin
    verdict_t v;
    if (rsp_if.valid && rsp_if.ready) begin
      answered++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected result: number %0d is_prime %0b",
                   rsp_if.number_echo, rsp_if.is_prime);
      end else begin
        v = verdict_q.pop_front();
        if (v.prime) primes_seen++;
        if (rsp_if.number_echo !== v.number || rsp_if.is_prime !== v.prime) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("mismatch: expected %0d/%0b got %0d/%0b", v.number, v.prime,
                     rsp_if.number_echo, rsp_if.is_prime);
        end
      end
    end
  end

  // Drive ready for the next cycle; count down a long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("odd_bitmap_prime_sieve_test_top_tb NOT OK");
        $finish;
      end
    end
  end

  // Extremes, small numbers, even numbers and the largest 32-bit prime
  task automatic test_directed();
    logic [NumW-1:0] pick [] = '{0, 1, 2, 3, 4, 5, 9, 15, 65519, 65521, 65535, 65536,
                                  65537, 65539, 1048573, 4294836225, 4294967294,
                                  4294967295, 4294967291, 32'hAAAA_AAAB, 32'h5555_5555};
    foreach (pick[k]) send_query(pick[k]);
  endtask

  function automatic logic [NumW-1:0] random_number();
    logic [NumW-1:0] n;
    n = $urandom();
    case ($urandom_range(4))
      0, 1: return $urandom_range(Limit - 1);
      2: return $urandom_range(1 << 20, Limit);
      3: return {n[NumW-1:1], 1'b0};
      default: return n - (n % 3) + 3 * (n < 6);
    endcase
  endfunction

  task automatic test_random(int unsigned count);
    repeat (count) send_query(random_number());
  endtask

  // Stall the receiver for a long stretch while requests keep coming
  task automatic test_backpressure();
    wait_drained();
    hold_left <= 400;
    repeat (8) send_query(random_number());
  endtask

  initial begin
    req_if.valid  = 1'b0;
    req_if.number = '0;
    rsp_if.ready  = 1'b0;
    build_composite_map();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    send_idle_pct = 25;
    recv_idle_pct = 69;
    test_random(30);
    test_backpressure();
    wait_drained();
    send_idle_pct = 69;
    recv_idle_pct = 25;
    test_random(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(30);
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d answers, %0d prime, %0d at or above the sieve limit",
             answered, primes_seen, big_queries);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("odd_bitmap_prime_sieve_test_top_tb OK");
    end else begin
      $display("odd_bitmap_prime_sieve_test_top_tb NOT OK");
    end
    $finish;
  end

endmodule
